// File: sv/fqmc_pkg.sv
package fqmc_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 5;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// File: sv/fifo_queue_with_max_and_count_core.sv
// A push, or a failed operation, is registered at the output in the cycle after acceptance.
// A successful pop is registered at the output when the maximum scan finishes and the maximum has settled.
// Pushes are accepted one transaction per cycle while the output is not stalled; no new transaction
// is taken during a pop's scan, in which the partial-maximum chain moves one cell per cycle.
// Reset clears the count, the valid bits, the maximum and the controller; entry data is not reset.
module fifo_queue_with_max_and_count_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  fqmc_pkg::data_t         push_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    ok,
	output fqmc_pkg::data_t         popped_value,
	output logic [fqmc_pkg::COUNT_W-1:0] count_after,
	output fqmc_pkg::data_t         largest_held,
	output logic                    is_empty
);

	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned SCAN_W = $clog2(DEPTH);

	fqmc_pkg::state_t state_q;
	fqmc_pkg::state_t state_d;

	logic [CNT_W-1:0]  count_q;
	logic [SCAN_W-1:0] scan_q;
	fqmc_pkg::data_t   max_q;
	fqmc_pkg::data_t   pop_val_q;

	logic                        out_valid_q;
	logic                        ok_q;
	fqmc_pkg::data_t             popped_q;
	logic [fqmc_pkg::COUNT_W-1:0] cnt_out_q;
	fqmc_pkg::data_t             largest_q;
	logic                        empty_q;

	fqmc_pkg::data_t   cell_val  [DEPTH];
	fqmc_pkg::data_t   cell_pmax [DEPTH];
	logic [DEPTH-1:0]  cell_vld;

	logic            take;
	logic            push_ok;
	logic            pop_ok;
	logic            scan_done;
	logic            fast_done;
	logic [CNT_W-1:0] cnt_next;
	fqmc_pkg::data_t  max_next;

	assign take      = in_valid && !in_stall;
	assign push_ok   = take && (operation == fqmc_pkg::OP_PUSH) && (count_q != CNT_W'(DEPTH));
	assign pop_ok    = take && (operation == fqmc_pkg::OP_POP) && (count_q != '0);
	assign fast_done = take && !pop_ok;
	assign scan_done = (state_q == fqmc_pkg::ST_SCAN) && (scan_q == SCAN_W'(DEPTH - 1));
	assign cnt_next  = push_ok ? (count_q + 1'b1) : count_q;

	always_comb begin
		if (push_ok && ((count_q == '0) || (push_value > max_q))) begin
			max_next = push_value;
		end else begin
			max_next = max_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fqmc_pkg::ST_IDLE: begin
				if (pop_ok) begin
					state_d = fqmc_pkg::ST_SCAN;
				end
			end
			fqmc_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = fqmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fqmc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			fqmc_pkg::ST_IDLE: begin
				in_stall = out_valid_q && out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqmc_pkg::ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			max_q   <= '0;
		end else begin
			state_q <= state_d;
			if (pop_ok) begin
				count_q <= count_q - 1'b1;
				scan_q  <= '0;
			end else begin
				count_q <= cnt_next;
				if (state_q == fqmc_pkg::ST_SCAN) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (scan_done) begin
				max_q <= cell_pmax[0];
			end else begin
				max_q <= max_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ok) begin
			pop_val_q <= cell_val[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fast_done || scan_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fast_done) begin
			ok_q      <= push_ok;
			popped_q  <= '0;
			cnt_out_q <= fqmc_pkg::COUNT_W'(cnt_next);
			largest_q <= (cnt_next == '0) ? '0 : max_next;
			empty_q   <= (cnt_next == '0);
		end else if (scan_done) begin
			ok_q      <= 1'b1;
			popped_q  <= pop_val_q;
			cnt_out_q <= fqmc_pkg::COUNT_W'(count_q);
			largest_q <= (count_q == '0) ? '0 : cell_pmax[0];
			empty_q   <= (count_q == '0);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		fqmc_pkg::cell_ctl_t ctl;
		fqmc_pkg::data_t     nbr_val;
		fqmc_pkg::data_t     nbr_pmax;
		logic                nbr_vld;

		assign ctl.shift = pop_ok;
		assign ctl.load  = push_ok && (count_q == CNT_W'(i));

		if (i == DEPTH - 1) begin : g_tail
			assign nbr_val  = '0;
			assign nbr_pmax = '0;
			assign nbr_vld  = 1'b0;
		end else begin : g_body
			assign nbr_val  = cell_val[i+1];
			assign nbr_pmax = cell_pmax[i+1];
			assign nbr_vld  = cell_vld[i+1];
		end

		fqmc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.push_value (push_value),
			.nbr_val    (nbr_val),
			.nbr_vld    (nbr_vld),
			.nbr_pmax   (nbr_pmax),
			.val        (cell_val[i]),
			.vld        (cell_vld[i]),
			.pmax       (cell_pmax[i])
		);
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign popped_value = popped_q;
	assign count_after  = cnt_out_q;
	assign largest_held = largest_q;
	assign is_empty     = empty_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count exceeds depth");

	a_scan_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fqmc_pkg::ST_SCAN) |-> in_stall)
		else $error("input taken during max scan");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not lower count");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cell_vld[0] == (count_q != '0))
		else $error("head cell valid disagrees with count");
`endif

endmodule

// File: sv/fqmc_cell.sv
module fqmc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fqmc_pkg::cell_ctl_t ctl,
	input  fqmc_pkg::data_t     push_value,
	input  fqmc_pkg::data_t     nbr_val,
	input  logic                nbr_vld,
	input  fqmc_pkg::data_t     nbr_pmax,
	output fqmc_pkg::data_t     val,
	output logic                vld,
	output fqmc_pkg::data_t     pmax
);

	fqmc_pkg::data_t val_q;
	fqmc_pkg::data_t pmax_q;
	logic            vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= nbr_vld;
		end else if (ctl.load) begin
			vld_q <= 1'b1;
		end
	end

	// advance toward the head on pop, load at the tail on push
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= nbr_val;
		end else if (ctl.load) begin
			val_q <= push_value;
		end
	end

	// partial maximum flows from the tail toward the head
	always_ff @(posedge clk) begin
		if (nbr_vld && (nbr_pmax > val_q)) begin
			pmax_q <= nbr_pmax;
		end else begin
			pmax_q <= val_q;
		end
	end

	assign val  = val_q;
	assign vld  = vld_q;
	assign pmax = pmax_q;

endmodule
